// ===== rtl/fgl_pkg.sv =====
`timescale 1ns / 1ps

package fgl_pkg;

   // Input item modes.
   localparam logic [1:0] MODE_LOAD_BLOCK = 2'd0;
   localparam logic [1:0] MODE_LOAD_GLYPH = 2'd1;
   localparam logic [1:0] MODE_LOOKUP     = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_LOADED   = 2'd0;
   localparam logic [1:0] STATUS_FOUND    = 2'd1;
   localparam logic [1:0] STATUS_REPLACED = 2'd2;
   localparam logic [1:0] STATUS_MISSING  = 2'd3;

   // Code looked up again after a miss: the question mark.
   localparam logic [31:0] FALLBACK_CODE = 32'h0000_003F;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] slot;
      logic [31:0] code_value;
      logic [11:0] block_first_slot;
      logic [12:0] block_glyph_count;
      logic [7:0]  block_width;
      logic [7:0]  block_height;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] glyph_slot;
      logic [7:0]  glyph_width;
      logic [7:0]  glyph_height;
      logic [12:0] bitmap_bytes;
   } rsp_type;

   // One block descriptor as it is kept in the block table memory.
   typedef struct packed {
      logic [11:0] first_slot;
      logic [12:0] glyph_count;
      logic [7:0]  width;
      logic [7:0]  height;
   } blk_desc_type;

endpackage

// ===== rtl/fgl_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module fgl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/font_glyph_lookup.sv =====
`timescale 1ns / 1ps
// A load writes its memory when it is accepted; its result then passes through S_OUT into
// the output register. A lookup reads each block's descriptor, then its first and last code,
// skipping an empty block or one whose range misses the code; the first block that covers
// the code is searched by halving, and a miss may retry once with the question mark.
// One item at a time: input stalls until the result is loaded into the output register.
// Reset (synchronous, active high) clears control state and blocks_in_use, not the memories.
module font_glyph_lookup #(
   parameter int MAX_BLOCKS = 16,
   parameter int MAX_GLYPHS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fgl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fgl_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);

   // Address widths of the two memories and the width of the block scan counter,
   // which must be able to hold MAX_BLOCKS itself.
   localparam int BAW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int GAW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
   localparam int BCW = $clog2(MAX_BLOCKS + 1);

   // The sequencer. A lookup scans the blocks in order: read the descriptor, then the
   // first and the last code of the block. The first block whose code range covers the
   // target is searched by halving; its outcome ends the pass, hit or miss.
   typedef enum logic [2:0] {
      S_IDLE,
      S_BLK_RD,
      S_BLK_WAIT,
      S_FIRST_WAIT,
      S_LAST_WAIT,
      S_PROBE,
      S_CMP,
      S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [4:0]       blocks_in_use_ff;
   logic [31:0]      tgt_ff, tgt_in;
   logic             retry_ff, retry_in;
   logic [BCW-1:0]   blk_idx_ff, blk_idx_in;
   logic [11:0]      first_ff, first_in;
   logic [12:0]      cnt_ff, cnt_in;
   logic [7:0]       width_ff, width_in;
   logic [7:0]       height_ff, height_in;
   logic [12:0]      lo_ff, lo_in;
   logic [12:0]      hi_ff, hi_in;
   logic [12:0]      mid_ff, mid_in;
   fgl_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff;
   fgl_pkg::rsp_type rsp_data_ff;

   logic                   accept;
   logic                   out_free;
   logic                   blk_we;
   logic                   glyph_we;
   logic [40:0]            blk_rdata;
   fgl_pkg::blk_desc_type  blk_desc;
   logic [31:0]            glyph_rdata;
   logic [GAW-1:0]         glyph_raddr;
   logic                   scan_done;
   logic                   first_ok;
   logic [31:0]            room;
   logic [12:0]            cnt_calc;
   logic [12:0]            mid_calc;
   logic [13:0]            probe_sum;
   logic [13:0]            last_sum;
   logic [15:0]            area;
   logic [16:0]            area_round;
   logic                   miss;
   logic                   next_block;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // The result register may be refilled when it is empty or its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Loads write the memories in the cycle they are accepted. No read is in flight then,
   // since lookups run only while the input side is stalled.
   assign blk_we   = accept && (req_data.mode == fgl_pkg::MODE_LOAD_BLOCK) &&
                     (32'(req_data.slot) < MAX_BLOCKS);
   assign glyph_we = accept && (req_data.mode == fgl_pkg::MODE_LOAD_GLYPH) &&
                     (32'(req_data.slot) < MAX_GLYPHS);

   fgl_ram #(
      .WIDTH(41),
      .DEPTH(MAX_BLOCKS)
   ) u_block_ram (
      .clock  (clock),
      .wr_en  (blk_we),
      .wr_addr(BAW'(req_data.slot)),
      .wr_data({req_data.block_first_slot, req_data.block_glyph_count,
                req_data.block_width, req_data.block_height}),
      .rd_addr(blk_idx_ff[BAW-1:0]),
      .rd_data(blk_rdata)
   );

   fgl_ram #(
      .WIDTH(32),
      .DEPTH(MAX_GLYPHS)
   ) u_glyph_ram (
      .clock  (clock),
      .wr_en  (glyph_we),
      .wr_addr(GAW'(req_data.slot)),
      .wr_data(req_data.code_value),
      .rd_addr(glyph_raddr),
      .rd_data(glyph_rdata)
   );

   assign blk_desc = fgl_pkg::blk_desc_type'(blk_rdata);

   // The scan ends at blocks_in_use, and never goes past the table.
   assign scan_done = (32'(blk_idx_ff) >= 32'(blocks_in_use_ff)) ||
                      (32'(blk_idx_ff) >= MAX_BLOCKS);

   // A block is clipped at the end of the glyph memory. One that starts beyond it
   // counts as empty and is skipped, like a block with no glyphs.
   assign first_ok = 32'(blk_desc.first_slot) < MAX_GLYPHS;
   assign room     = MAX_GLYPHS - 32'(blk_desc.first_slot);
   always_comb begin
      if (!first_ok) begin
         cnt_calc = '0;
      end else if (32'(blk_desc.glyph_count) < room) begin
         cnt_calc = blk_desc.glyph_count;
      end else begin
         cnt_calc = 13'(room);
      end
   end

   // The search keeps lo and an exclusive upper bound, so no bound ever goes negative.
   assign mid_calc  = lo_ff + ((hi_ff - lo_ff - 13'd1) >> 1);
   assign probe_sum = {2'b00, first_ff} + {1'b0, mid_ff};
   assign last_sum  = {2'b00, first_ff} + {1'b0, cnt_ff} - 14'd1;

   // Bitmap size of a glyph: pixels rounded up to whole bytes.
   assign area       = {8'b0, width_ff} * {8'b0, height_ff};
   assign area_round = {1'b0, area} + 17'd7;

   always_comb begin
      state_in    = state_ff;
      tgt_in      = tgt_ff;
      retry_in    = retry_ff;
      blk_idx_in  = blk_idx_ff;
      first_in    = first_ff;
      cnt_in      = cnt_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      res_in      = res_ff;
      glyph_raddr = '0;
      miss        = 1'b0;
      next_block  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Loads and the unused mode answer with an all-zero result.
               res_in = '0;
               res_in.status = fgl_pkg::STATUS_LOADED;
               if (req_data.mode == fgl_pkg::MODE_LOOKUP) begin
                  tgt_in     = req_data.code_value;
                  retry_in   = 1'b0;
                  blk_idx_in = '0;
                  state_in   = S_BLK_RD;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_BLK_RD: begin
            // The descriptor read is issued here from blk_idx_ff.
            if (scan_done) begin
               miss = 1'b1;
            end else begin
               state_in = S_BLK_WAIT;
            end
         end
         S_BLK_WAIT: begin
            first_in    = blk_desc.first_slot;
            cnt_in      = cnt_calc;
            width_in    = blk_desc.width;
            height_in   = blk_desc.height;
            glyph_raddr = GAW'(blk_desc.first_slot);
            if (cnt_calc == 13'd0) begin
               next_block = 1'b1;
            end else begin
               state_in = S_FIRST_WAIT;
            end
         end
         S_FIRST_WAIT: begin
            glyph_raddr = GAW'(last_sum);
            if (tgt_ff < glyph_rdata) begin
               next_block = 1'b1;
            end else begin
               state_in = S_LAST_WAIT;
            end
         end
         S_LAST_WAIT: begin
            if (tgt_ff > glyph_rdata) begin
               next_block = 1'b1;
            end else begin
               lo_in    = '0;
               hi_in    = cnt_ff;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // An empty interval means the chosen block does not hold the code.
            if (lo_ff >= hi_ff) begin
               miss = 1'b1;
            end else begin
               mid_in      = mid_calc;
               glyph_raddr = GAW'({2'b00, first_ff} + {1'b0, mid_calc});
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            if (glyph_rdata == tgt_ff) begin
               res_in.status       = retry_ff ? fgl_pkg::STATUS_REPLACED
                                              : fgl_pkg::STATUS_FOUND;
               res_in.glyph_slot   = probe_sum[11:0];
               res_in.glyph_width  = width_ff;
               res_in.glyph_height = height_ff;
               res_in.bitmap_bytes = area_round[15:3];
               state_in            = S_OUT;
            end else begin
               if (glyph_rdata < tgt_ff) begin
                  lo_in = mid_ff + 13'd1;
               end else begin
                  hi_in = mid_ff;
               end
               state_in = S_PROBE;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (next_block) begin
         blk_idx_in = BCW'(blk_idx_ff + 1'b1);
         state_in   = S_BLK_RD;
      end

      // A miss retries once with the question mark, unless that was the code sought.
      if (miss) begin
         if (!retry_ff && (tgt_ff != fgl_pkg::FALLBACK_CODE)) begin
            tgt_in     = fgl_pkg::FALLBACK_CODE;
            retry_in   = 1'b1;
            blk_idx_in = '0;
            state_in   = S_BLK_RD;
         end else begin
            res_in        = '0;
            res_in.status = fgl_pkg::STATUS_MISSING;
            state_in      = S_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         blocks_in_use_ff <= '0;
      end else begin
         state_ff   <= state_in;
         tgt_ff     <= tgt_in;
         retry_ff   <= retry_in;
         blk_idx_ff <= blk_idx_in;
         first_ff   <= first_in;
         cnt_ff     <= cnt_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         mid_ff     <= mid_in;
         res_ff     <= res_in;
         if (csr_wr_en) begin
            blocks_in_use_ff <= csr_wr_data;
         end
         // The output register holds the last beat until the far side takes it.
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/fgl_checker.sv =====
`timescale 1ns / 1ps

module fgl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fgl_pkg::rsp_type rsp_data
);

   logic [15:0] area;
   logic [16:0] area_round;

   assign area       = {8'b0, rsp_data.glyph_width} * {8'b0, rsp_data.glyph_height};
   assign area_round = {1'b0, area} + 17'd7;

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Items are handled one at a time: the input side stalls right after a beat.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in work");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Loads and misses carry no glyph; hits carry a consistent bitmap size.
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (((rsp_data.status == fgl_pkg::STATUS_LOADED) ||
           (rsp_data.status == fgl_pkg::STATUS_MISSING)) &&
          (rsp_data.glyph_slot == 12'd0) && (rsp_data.glyph_width == 8'd0) &&
          (rsp_data.glyph_height == 8'd0) && (rsp_data.bitmap_bytes == 13'd0)) ||
         (((rsp_data.status == fgl_pkg::STATUS_FOUND) ||
           (rsp_data.status == fgl_pkg::STATUS_REPLACED)) &&
          (rsp_data.bitmap_bytes == area_round[15:3])))
      else $error("result fields inconsistent with status");

endmodule

bind font_glyph_lookup fgl_checker u_fgl_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// ===== test/font_glyph_lookup_tb.sv =====
`timescale 1ns / 1ps

module font_glyph_lookup_tb;

   // Geometry of the block as instantiated here (the default parameters).
   localparam int BLOCK_SLOTS = 16;
   localparam int GLYPH_SLOTS = 4096;

   // The fourth mode value has no name in the package; the block must treat it
   // like a load that changes nothing.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Marks a directed row whose result is worked out by the predictor rather than
   // typed into the table.
   localparam int PREDICTED = -1;

   // Number of random beats to send after the directed table.
   localparam int RANDOM_BEATS = 2000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   fgl_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   fgl_pkg::rsp_type rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = '0;

   font_glyph_lookup dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The testbench's own copy of the font: the block descriptors, the glyph code
   // memory and the number of blocks scanned per lookup. Alongside them we keep a
   // record of which entries have been written. The block leaves both memories
   // undefined after reset, so no lookup may ever make it read an entry that was
   // never loaded; the random stimulus consults these flags before issuing a lookup.
   fgl_pkg::blk_desc_type font_blocks [BLOCK_SLOTS];
   logic [31:0]  stored_codes [GLYPH_SLOTS];
   bit           block_written [BLOCK_SLOTS];
   bit           code_written [GLYPH_SLOTS];
   logic [4:0]   scan_setting = '0;

   // Results still owed by the block, oldest first.
   fgl_pkg::rsp_type awaited_results [$];

   int beats_sent = 0;
   int mismatches = 0;

   // One row of the directed table: an optional register write made before the
   // beat, the beat itself, and the result if it is typed in by hand.
   typedef struct {
      int               cfg;
      fgl_pkg::req_type beat;
      int               exp_status;
      fgl_pkg::rsp_type exp;
   } stim_row_type;

   stim_row_type directed_rows [$];

   // Both sides run without any idling through this stretch of the run, so that
   // back-to-back beats are seen too.
   function automatic bit quiet_stretch();
      return beats_sent >= 700 && beats_sent < 1000;
   endfunction

   // A register value above the table size still scans the whole table only.
   function automatic int scan_limit();
      return (int'(scan_setting) > BLOCK_SLOTS) ? BLOCK_SLOTS : int'(scan_setting);
   endfunction

   // Glyph count of a block once it has been clipped at the end of the code
   // memory. Zero means that the lookup skips the block.
   function automatic int usable_count(input fgl_pkg::blk_desc_type desc);
      int room;
      room = GLYPH_SLOTS - int'(desc.first_slot);
      return (int'(desc.glyph_count) < room) ? int'(desc.glyph_count) : room;
   endfunction

   // Scans the blocks in use in order. The first block whose code range holds the
   // codepoint is the only one searched: a miss inside it ends the search with no
   // look at later blocks.
   function automatic bit find_glyph(input logic [31:0] codepoint,
                                     output logic [11:0] hit_slot, output int hit_blk);
      int i, first, count, lo, hi, mid;
      logic [31:0] probe;
      hit_slot = '0;
      hit_blk = 0;
      for (i = 0; i < scan_limit(); i++) begin
         first = int'(font_blocks[i].first_slot);
         count = usable_count(font_blocks[i]);
         if (count == 0) continue;
         if (codepoint < stored_codes[first] || codepoint > stored_codes[first + count - 1])
            continue;
         lo = 0;
         hi = count - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            probe = stored_codes[first + mid];
            if (probe == codepoint) begin
               hit_slot = 12'(first + mid);
               hit_blk = i;
               return 1'b1;
            end
            if (probe < codepoint) lo = mid + 1;
            else hi = mid - 1;
         end
         return 1'b0;
      end
      return 1'b0;
   endfunction

   // Applies one accepted beat to the font copy and returns the result that the
   // block owes for it. Loads and the unused mode answer with a bare status.
   function automatic fgl_pkg::rsp_type predict_glyph_result(input fgl_pkg::req_type beat);
      fgl_pkg::rsp_type res;
      logic [11:0] hit_slot;
      int hit_blk, w, h;
      res = '0;
      res.status = fgl_pkg::STATUS_LOADED;
      case (beat.mode)
         fgl_pkg::MODE_LOAD_BLOCK: begin
            // Block numbers past the table are dropped silently.
            if (int'(beat.slot) < BLOCK_SLOTS) begin
               font_blocks[beat.slot].first_slot = beat.block_first_slot;
               font_blocks[beat.slot].glyph_count = beat.block_glyph_count;
               font_blocks[beat.slot].width = beat.block_width;
               font_blocks[beat.slot].height = beat.block_height;
               block_written[beat.slot] = 1'b1;
            end
         end
         fgl_pkg::MODE_LOAD_GLYPH: begin
            stored_codes[beat.slot] = beat.code_value;
            code_written[beat.slot] = 1'b1;
         end
         fgl_pkg::MODE_LOOKUP: begin
            // A miss is retried once with the question mark, unless the question
            // mark itself was the codepoint asked for.
            if (find_glyph(beat.code_value, hit_slot, hit_blk))
               res.status = fgl_pkg::STATUS_FOUND;
            else if (beat.code_value != fgl_pkg::FALLBACK_CODE &&
                     find_glyph(fgl_pkg::FALLBACK_CODE, hit_slot, hit_blk))
               res.status = fgl_pkg::STATUS_REPLACED;
            else
               res.status = fgl_pkg::STATUS_MISSING;
            if (res.status != fgl_pkg::STATUS_MISSING) begin
               w = int'(font_blocks[hit_blk].width);
               h = int'(font_blocks[hit_blk].height);
               res.glyph_slot = hit_slot;
               res.glyph_width = 8'(w);
               res.glyph_height = 8'(h);
               res.bitmap_bytes = 13'((w * h + 7) / 8);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // True when a lookup under the current setting would read only descriptors
   // and glyph codes that have been loaded.
   function automatic bit lookup_safe();
      int i, s, first, count;
      for (i = 0; i < scan_limit(); i++) begin
         if (!block_written[i]) return 1'b0;
         first = int'(font_blocks[i].first_slot);
         count = usable_count(font_blocks[i]);
         for (s = 0; s < count; s++)
            if (!code_written[first + s]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // A beat with every field random within its range; callers then fix the
   // fields that matter for the mode they want.
   function automatic fgl_pkg::req_type random_beat();
      fgl_pkg::req_type r;
      r.mode = 2'($urandom_range(0, 3));
      r.slot = 12'($urandom);
      r.code_value = $urandom;
      r.block_first_slot = 12'($urandom);
      r.block_glyph_count = 13'($urandom_range(0, GLYPH_SLOTS));
      r.block_width = 8'($urandom);
      r.block_height = 8'($urandom);
      return r;
   endfunction

   // Codepoint for a lookup. Most are codes that sit in a block in use, either
   // exactly (usually a hit) or one off (often a miss inside the range, which
   // then brings in the question mark retry). The rest are the edges of the code
   // space, the question mark itself and arbitrary values.
   function automatic logic [31:0] pick_lookup_code();
      int b, first, count;
      logic [31:0] code;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return fgl_pkg::FALLBACK_CODE;
         2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
         default: begin
            if (scan_limit() == 0) return $urandom_range(0, 'h7F);
            b = $urandom_range(0, scan_limit() - 1);
            count = usable_count(font_blocks[b]);
            if (count == 0) return $urandom_range(0, 'h7F);
            first = int'(font_blocks[b].first_slot);
            code = stored_codes[first + $urandom_range(0, count - 1)];
            case ($urandom_range(0, 5))
               0: return code + 1;
               1: return code - 1;
               default: return code;
            endcase
         end
      endcase
   endfunction

   // Presents one beat, holding it steady until the block takes it, then records
   // what the block owes for it. A typed result from the directed table replaces
   // the predicted one, but the beat still goes through the predictor so that its
   // copy of the font stays current.
   task automatic send_beat(input fgl_pkg::req_type beat, input bit typed,
                            input fgl_pkg::rsp_type typed_rsp);
      fgl_pkg::rsp_type predicted;
      while (!quiet_stretch() && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_glyph_result(beat);
      awaited_results.push_back(typed ? typed_rsp : predicted);
      beats_sent++;
   endtask

   // The register may only change while the block is idle: stop sending, wait for
   // every owed result, and let the block settle before the write.
   task automatic set_blocks_in_use(input int value);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= 5'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      scan_setting = 5'(value);
   endtask

   task automatic stim(input int cfg, input logic [1:0] mode, input int slot,
                       input logic [31:0] code, input int first, input int count,
                       input int w, input int h, input int st, input int gs,
                       input int gw, input int gh, input int bb);
      stim_row_type row;
      row.cfg = cfg;
      row.beat.mode = mode;
      row.beat.slot = 12'(slot);
      row.beat.code_value = code;
      row.beat.block_first_slot = 12'(first);
      row.beat.block_glyph_count = 13'(count);
      row.beat.block_width = 8'(w);
      row.beat.block_height = 8'(h);
      row.exp_status = st;
      row.exp.status = 2'(st);
      row.exp.glyph_slot = 12'(gs);
      row.exp.glyph_width = 8'(gw);
      row.exp.glyph_height = 8'(gh);
      row.exp.bitmap_bytes = 13'(bb);
      directed_rows.push_back(row);
   endtask

   // Loads one block: its glyph codes first, then its descriptor. Most blocks are
   // short sorted runs; some are empty, some run off the end of the code memory
   // and get clipped, some reach the top of the code space, many look like text
   // around the question mark so that the retry can hit, and a few hold
   // scrambled codes that the binary search may miss.
   task automatic load_font_block(input int blk);
      fgl_pkg::req_type r;
      int kind, first, count, room, used, s, step;
      bit scrambled;
      logic [31:0] code;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         first = $urandom_range(0, GLYPH_SLOTS - 1);
         count = 0;
      end else if (kind == 1) begin
         first = $urandom_range(GLYPH_SLOTS - 16, GLYPH_SLOTS - 1);
         count = $urandom_range(0, 1) ? GLYPH_SLOTS : $urandom_range(1, 40);
      end else begin
         first = $urandom_range(0, GLYPH_SLOTS - 16);
         count = $urandom_range(1, 12);
      end
      room = GLYPH_SLOTS - first;
      used = (count < room) ? count : room;
      step = (kind >= 6) ? 1 : $urandom_range(1, 5000);
      if (kind >= 6) code = $urandom_range('h20, 'h3F);
      else if (kind == 5) code = 32'hFFFF_FFFF - 32'((used - 1) * step);
      else code = $urandom_range(0, 32'hF000_0000);
      scrambled = ($urandom_range(0, 9) == 0);
      for (s = 0; s < used; s++) begin
         r = random_beat();
         r.mode = fgl_pkg::MODE_LOAD_GLYPH;
         r.slot = 12'(first + s);
         r.code_value = scrambled ? $urandom : code;
         send_beat(r, 1'b0, '0);
         code = code + step;
      end
      r = random_beat();
      r.mode = fgl_pkg::MODE_LOAD_BLOCK;
      r.slot = 12'(blk);
      r.block_first_slot = 12'(first);
      r.block_glyph_count = 13'(count);
      if ($urandom_range(0, 7) == 0) r.block_width = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) r.block_height = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      send_beat(r, 1'b0, '0);
   endtask

   // One random phase: a new register setting, a few blocks reloaded (all of them
   // in the first phase, so that any setting is safe afterwards), then a run of
   // lookups with stray beats mixed in.
   task automatic run_font_phase(input int phase);
      fgl_pkg::req_type r;
      int setting, reloads, lookups, j, pick;
      case (phase)
         0: setting = BLOCK_SLOTS;
         1: setting = 31;
         2: setting = 0;
         3: setting = 1;
         default: setting = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                         : $urandom_range(1, BLOCK_SLOTS);
      endcase
      set_blocks_in_use(setting);
      reloads = (phase == 0) ? BLOCK_SLOTS : $urandom_range(1, 4);
      for (j = 0; j < reloads; j++)
         load_font_block((phase == 0) ? j : $urandom_range(0, BLOCK_SLOTS - 1));
      lookups = $urandom_range(40, 80);
      for (j = 0; j < lookups; j++) begin
         r = random_beat();
         pick = $urandom_range(0, 99);
         if (pick < 80 && lookup_safe()) begin
            r.mode = fgl_pkg::MODE_LOOKUP;
            r.code_value = pick_lookup_code();
         end else if (pick < 86) begin
            r.mode = MODE_UNUSED;
         end else if (pick < 92) begin
            // Descriptor load to a block number past the table.
            r.mode = fgl_pkg::MODE_LOAD_BLOCK;
            r.slot = 12'($urandom_range(BLOCK_SLOTS, GLYPH_SLOTS - 1));
         end else if (pick < 97) begin
            // Stray code write; it may land inside a block and unsort it.
            r.mode = fgl_pkg::MODE_LOAD_GLYPH;
         end else if (lookup_safe()) begin
            r.mode = fgl_pkg::MODE_LOOKUP;
         end else begin
            r.mode = MODE_UNUSED;
         end
         send_beat(r, 1'b0, '0);
      end
   endtask

   // The result side stalls at random, except through the quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_stretch() && ($urandom_range(0, 99) < 13);
      end
   end

   function automatic string rsp_text(input fgl_pkg::rsp_type r);
      return $sformatf("st=%0d slot=%0d w=%0d h=%0d bytes=%0d", r.status, r.glyph_slot,
                       r.glyph_width, r.glyph_height, r.bitmap_bytes);
   endfunction

   task automatic report_mismatch(input string what, input fgl_pkg::rsp_type want,
                                  input fgl_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected %s, got %s", $time, what, rsp_text(want),
                  rsp_text(got));
   endtask

   // Every result beat taken is checked against the oldest owed result.
   always @(posedge clock) begin : rsp_check
      fgl_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_data);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.glyph_slot !== want.glyph_slot ||
                rsp_data.glyph_width !== want.glyph_width ||
                rsp_data.glyph_height !== want.glyph_height ||
                rsp_data.bitmap_bytes !== want.bitmap_bytes)
               report_mismatch("wrong result", want, rsp_data);
         end
      end
   end

   initial begin
      int i, phase, random_start;

      // Directed table. Columns: register write before the beat (-1 for none),
      // mode, slot, code, first slot, glyph count, width, height, then the typed
      // result (status, slot, width, height, bytes) or PREDICTED.
      //
      // Right after reset no block is in use, so a lookup misses and the retry
      // finds nothing either.
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, 'h41, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_MISSING), 0, 0, 0, 0);
      // The unused mode only answers with a bare status.
      stim(-1, MODE_UNUSED, 'hABC, 'h5A5A_A5A5, 'h123, 'hFFF, 'h81, 'h18,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      // A descriptor for a block number past the table is dropped.
      stim(-1, fgl_pkg::MODE_LOAD_BLOCK, 'hFFF, 'hFFFF_FFFF, 'hFFF, GLYPH_SLOTS, 'hFF, 'hFF,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      // Codes for a block at the very end of memory, up to the largest code.
      stim(-1, fgl_pkg::MODE_LOAD_GLYPH, 'hFFF, 'hFFFF_FFFF, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOAD_GLYPH, 'hFFD, 'h1000, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOAD_GLYPH, 'hFFE, 'h2000, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      // A small text block that holds the question mark.
      stim(-1, fgl_pkg::MODE_LOAD_GLYPH, 4, 'h20, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOAD_GLYPH, 5, 'h3F, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOAD_GLYPH, 6, 'h41, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOAD_GLYPH, 7, 'h5A, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      // Block 0 is empty and must be skipped; block 2 asks for a count as large as the code
      // memory and is clipped to the three slots left at the end of memory.
      stim(-1, fgl_pkg::MODE_LOAD_BLOCK, 0, 0, 0, 0, 1, 1,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOAD_BLOCK, 1, 0, 4, 4, 8, 16,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOAD_BLOCK, 2, 0, 'hFFD, GLYPH_SLOTS, 255, 255,
           int'(fgl_pkg::STATUS_LOADED), 0, 0, 0, 0);
      // Plain hit, a miss inside a range that falls back to the question mark, the largest
      // code with the largest glyph, the question mark, codes below every block, a miss in block 2.
      stim(3, fgl_pkg::MODE_LOOKUP, 0, 'h41, 0, 0, 0, 0, PREDICTED, 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, 'h40, 0, 0, 0, 0, PREDICTED, 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, 'hFFFF_FFFF, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_FOUND), 'hFFF, 255, 255, 8129);
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, fgl_pkg::FALLBACK_CODE, 0, 0, 0, 0,
           PREDICTED, 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, 'h1, 0, 0, 0, 0, PREDICTED, 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, 'h0, 0, 0, 0, 0, PREDICTED, 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, 'h1800, 0, 0, 0, 0, PREDICTED, 0, 0, 0, 0);
      // Only the empty block in use: a missed question mark is not retried.
      stim(1, fgl_pkg::MODE_LOOKUP, 0, fgl_pkg::FALLBACK_CODE, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_MISSING), 0, 0, 0, 0);
      stim(-1, fgl_pkg::MODE_LOOKUP, 0, 'h41, 0, 0, 0, 0,
           int'(fgl_pkg::STATUS_MISSING), 0, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].cfg >= 0) set_blocks_in_use(directed_rows[i].cfg);
         send_beat(directed_rows[i].beat, directed_rows[i].exp_status != PREDICTED,
                   directed_rows[i].exp);
      end

      random_start = beats_sent;
      phase = 0;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         run_font_phase(phase);
         phase++;
      end

      // Let every owed result come out, then watch a while longer for strays.
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("font_glyph_lookup_tb passed");
      end else begin
         $display("font_glyph_lookup_tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #50_000_000;
      $display("font_glyph_lookup_tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/fgl_pkg.sv
rtl/fgl_ram.sv
rtl/font_glyph_lookup.sv
rtl/fgl_checker.sv
test/font_glyph_lookup_tb.sv
